>>> rtl/ohlcv_pkg.sv
// Shared widths, configuration register codes and divider handshake types.
package ohlcv_pkg;

	localparam int TIME_W    = 48;
	localparam int PRICE_W   = 32;
	localparam int VOL_W     = 48;
	localparam int TF_W      = 32;
	localparam int CNT_W     = 32;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 48;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_TIMEFRAME = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_START     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_END       = 2'd2;

	// register reset values
	localparam logic [TF_W-1:0]   TF_RESET    = 32'd60000;
	localparam logic [TIME_W-1:0] START_RESET = 48'd0;
	localparam logic [TIME_W-1:0] END_RESET   = 48'hFFFF_FFFF_FFFF;

	// request into the shared divider
	typedef struct packed {
		logic              start;
		logic [TIME_W-1:0] dividend;
		logic [TF_W-1:0]   divisor;
	} div_req_t;

	// answer from the shared divider
	typedef struct packed {
		logic              done;
		logic [TIME_W-1:0] quot;
		logic [TF_W-1:0]   rem;
	} div_rsp_t;

endpackage

>>> rtl/ohlcv_div.sv
// Restoring divider, 48-bit dividend by 32-bit divisor, one quotient bit per cycle.
module ohlcv_div (
	input  logic                clk,
	input  logic                arst_n,
	input  ohlcv_pkg::div_req_t req,
	output ohlcv_pkg::div_rsp_t rsp
);

	localparam int STEPS = ohlcv_pkg::TIME_W;
	localparam int CNT_W = $clog2(STEPS);
	localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(STEPS - 1);

	logic                           busy_q;
	logic                           done_q;
	logic [CNT_W-1:0]               cnt_q;
	logic [ohlcv_pkg::TIME_W-1:0]   dvd_q;
	logic [ohlcv_pkg::TF_W-1:0]     rem_q;
	logic [ohlcv_pkg::TF_W-1:0]     dsr_q;
	logic [ohlcv_pkg::TF_W:0]       trial;
	logic                           fits;

	// shift in the next dividend bit and try a subtract
	assign trial = {rem_q, dvd_q[ohlcv_pkg::TIME_W-1]};
	assign fits  = (trial >= {1'b0, dsr_q});

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST_STEP) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath: quotient bits enter at the bottom of the dividend register
	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			dsr_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[ohlcv_pkg::TIME_W-2:0], fits};
			rem_q <= fits ? ohlcv_pkg::TF_W'(trial - {1'b0, dsr_q})
			              : trial[ohlcv_pkg::TF_W-1:0];
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = dvd_q;
	assign rsp.rem  = rem_q;

endmodule

>>> rtl/ohlcv_bar_resampler.sv
// OHLCV bar resampler top level: sequencer, bar state and result register.
// Candles are taken one at a time; in_ready is high only while the block is idle. A candle
// that is dropped, ignored or merged into the open bar goes straight to the done state. A
// candle that opens a bar waits for one pass of the shared 48-step divider (t mod timeframe).
// A candle that closes a bar takes two divider passes, and its results (1 + up to MAX_FILL)
// go out one per cycle while the output side takes them without stall. All time division
// goes through that single bit-serial divider.
module ohlcv_bar_resampler #(
	parameter int MAX_FILL = 63
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration writes
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [ohlcv_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [ohlcv_pkg::CFG_DAT_W-1:0]   cfg_data,
	// candles in
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [ohlcv_pkg::TIME_W-1:0]      candle_time,
	input  logic [ohlcv_pkg::PRICE_W-1:0]     price_open,
	input  logic [ohlcv_pkg::PRICE_W-1:0]     price_high,
	input  logic [ohlcv_pkg::PRICE_W-1:0]     price_low,
	input  logic [ohlcv_pkg::PRICE_W-1:0]     price_close,
	input  logic [ohlcv_pkg::VOL_W-1:0]       trade_volume,
	input  logic                              end_of_data,
	// bars out
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [ohlcv_pkg::TIME_W-1:0]      bar_time,
	output logic [ohlcv_pkg::PRICE_W-1:0]     bar_open,
	output logic [ohlcv_pkg::PRICE_W-1:0]     bar_high,
	output logic [ohlcv_pkg::PRICE_W-1:0]     bar_low,
	output logic [ohlcv_pkg::PRICE_W-1:0]     bar_close,
	output logic [ohlcv_pkg::VOL_W-1:0]       bar_volume,
	output logic                              gap_filled,
	output logic                              gap_truncated,
	output logic [ohlcv_pkg::CNT_W-1:0]       missing_total,
	output logic                              last_of_run
);

	localparam int TW = ohlcv_pkg::TIME_W;
	localparam int PW = ohlcv_pkg::PRICE_W;
	localparam int VW = ohlcv_pkg::VOL_W;
	localparam int FW = ohlcv_pkg::TF_W;
	localparam int CW = ohlcv_pkg::CNT_W;
	localparam int FILL_W = (MAX_FILL < 1) ? 1 : $clog2(MAX_FILL + 1);

	// sequencer states
	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_DIV_GAP  = 3'd1;
	localparam logic [2:0] S_EMIT     = 3'd2;
	localparam logic [2:0] S_DIV_OPEN = 3'd3;
	localparam logic [2:0] S_DONE     = 3'd4;

	logic [2:0]        state_q;

	// configuration
	logic [FW-1:0]     tf_q;
	logic [TW-1:0]     start_q;
	logic [TW-1:0]     end_q;

	// bar state
	logic              active_q;
	logic              range_done_q;
	logic [TW-1:0]     cur_time_q;
	logic [PW-1:0]     cur_open_q;
	logic [PW-1:0]     cur_high_q;
	logic [PW-1:0]     cur_low_q;
	logic [PW-1:0]     cur_close_q;
	logic [VW-1:0]     cur_vol_q;
	logic [CW-1:0]     missing_q;

	// captured candle
	logic [TW-1:0]     t_q;
	logic [PW-1:0]     po_q;
	logic [PW-1:0]     ph_q;
	logic [PW-1:0]     pl_q;
	logic [PW-1:0]     pc_q;
	logic [VW-1:0]     pv_q;
	logic              eod_q;

	// gap fill walk
	logic [FILL_W-1:0] fill_left_q;
	logic [TW-1:0]     gap_time_q;

	// result register
	logic              out_valid_q;
	logic [TW-1:0]     o_time_q;
	logic [PW-1:0]     o_open_q;
	logic [PW-1:0]     o_high_q;
	logic [PW-1:0]     o_low_q;
	logic [PW-1:0]     o_close_q;
	logic [VW-1:0]     o_vol_q;
	logic              o_gap_q;
	logic              o_trunc_q;
	logic [CW-1:0]     o_missing_q;
	logic              o_last_q;

	ohlcv_pkg::div_req_t div_req;
	ohlcv_pkg::div_rsp_t div_rsp;

	logic [FW-1:0]     tf_eff;
	logic              in_acc;
	logic              out_acc;
	logic [TW:0]       bar_end;
	logic              in_range;
	logic              past_end;
	logic              is_gap;
	logic              need_div;
	logic              emit_last;
	logic [TW-1:0]     missing;
	logic              trunc;
	logic [FILL_W-1:0] fill;
	logic [TW-1:0]     room;
	logic [CW-1:0]     miss_next;
	logic [VW-1:0]     vol_sum;

	assign tf_eff    = (tf_q == '0) ? FW'(1) : tf_q;
	assign in_ready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign in_acc    = in_valid && in_ready;
	assign out_acc   = out_valid_q && out_ready;

	// candle classification against range and open bar
	assign bar_end   = {1'b0, cur_time_q} + (TW + 1)'(tf_eff);
	assign in_range  = !range_done_q && (candle_time >= start_q);
	assign past_end  = candle_time > end_q;
	assign is_gap    = {1'b0, candle_time} >= bar_end;
	assign need_div  = in_range && !past_end && (!active_q || is_gap);
	assign emit_last = (state_q == S_EMIT) && out_acc && (fill_left_q == '0);

	// divider requests: gap length (or alignment, with no open bar) on entry, bar alignment after the results
	always_comb begin
		div_req.start    = (in_acc && need_div) || emit_last;
		div_req.divisor  = tf_eff;
		div_req.dividend = t_q;
		if (state_q == S_IDLE) begin
			div_req.dividend = active_q ? (candle_time - cur_time_q) : candle_time;
		end
	end

	ohlcv_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// gap statistics from the quotient
	assign missing   = div_rsp.quot - TW'(1);
	assign trunc     = missing > TW'(MAX_FILL);
	assign fill      = trunc ? FILL_W'(MAX_FILL) : missing[FILL_W-1:0];
	assign room      = {{(TW - CW){1'b0}}, ~missing_q};
	assign miss_next = (missing >= room) ? '1 : (missing_q + missing[CW-1:0]);

	// saturating volume sum
	assign vol_sum = (trade_volume >= ~cur_vol_q) ? '1 : (cur_vol_q + trade_volume);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tf_q    <= ohlcv_pkg::TF_RESET;
			start_q <= ohlcv_pkg::START_RESET;
			end_q   <= ohlcv_pkg::END_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				ohlcv_pkg::CFG_TIMEFRAME: tf_q    <= cfg_data[FW-1:0];
				ohlcv_pkg::CFG_START:     start_q <= cfg_data[TW-1:0];
				ohlcv_pkg::CFG_END:       end_q   <= cfg_data[TW-1:0];
				default: ;
			endcase
		end
	end

	// captured candle fields
	always_ff @(posedge clk) begin
		if (in_acc) begin
			t_q   <= candle_time;
			po_q  <= price_open;
			ph_q  <= price_high;
			pl_q  <= price_low;
			pc_q  <= price_close;
			pv_q  <= trade_volume;
			eod_q <= end_of_data;
		end
	end

	// sequencer and bar state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			active_q     <= 1'b0;
			range_done_q <= 1'b0;
			cur_time_q   <= '0;
			cur_open_q   <= '0;
			cur_high_q   <= '0;
			cur_low_q    <= '0;
			cur_close_q  <= '0;
			cur_vol_q    <= '0;
			missing_q    <= '0;
			fill_left_q  <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						state_q <= S_DONE;
						if (in_range) begin
							if (past_end) begin
								range_done_q <= 1'b1;
							end else if (!active_q) begin
								state_q <= S_DIV_OPEN;
							end else if (is_gap) begin
								state_q <= S_DIV_GAP;
							end else begin
								// merge into the open bar
								if (price_high > cur_high_q) cur_high_q <= price_high;
								if (price_low < cur_low_q) cur_low_q <= price_low;
								cur_close_q <= price_close;
								cur_vol_q   <= vol_sum;
							end
						end
					end
				end
				S_DIV_GAP: begin
					if (div_rsp.done) begin
						missing_q   <= miss_next;
						fill_left_q <= fill;
						out_valid_q <= 1'b1;
						state_q     <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (out_acc) begin
						if (fill_left_q != '0) begin
							fill_left_q <= fill_left_q - 1'b1;
						end else begin
							out_valid_q <= 1'b0;
							state_q     <= S_DIV_OPEN;
						end
					end
				end
				S_DIV_OPEN: begin
					if (div_rsp.done) begin
						active_q    <= 1'b1;
						cur_time_q  <= t_q - {{(TW - FW){1'b0}}, div_rsp.rem};
						cur_open_q  <= po_q;
						cur_high_q  <= ph_q;
						cur_low_q   <= pl_q;
						cur_close_q <= pc_q;
						cur_vol_q   <= pv_q;
						state_q     <= S_DONE;
					end
				end
				S_DONE: begin
					// end of data drops the open bar and clears the run
					if (eod_q) begin
						active_q     <= 1'b0;
						range_done_q <= 1'b0;
						cur_time_q   <= '0;
						cur_open_q   <= '0;
						cur_high_q   <= '0;
						cur_low_q    <= '0;
						cur_close_q  <= '0;
						cur_vol_q    <= '0;
						missing_q    <= '0;
					end
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// result payload: finished bar first, then the gap bars
	always_ff @(posedge clk) begin
		if (state_q == S_DIV_GAP && div_rsp.done) begin
			o_time_q    <= cur_time_q;
			o_open_q    <= cur_open_q;
			o_high_q    <= cur_high_q;
			o_low_q     <= cur_low_q;
			o_close_q   <= cur_close_q;
			o_vol_q     <= cur_vol_q;
			o_gap_q     <= 1'b0;
			o_trunc_q   <= trunc;
			o_missing_q <= miss_next;
			o_last_q    <= (fill == '0);
			gap_time_q  <= cur_time_q + TW'(tf_eff);
		end else if (state_q == S_EMIT && out_acc && fill_left_q != '0) begin
			o_time_q   <= gap_time_q;
			o_open_q   <= cur_close_q;
			o_high_q   <= cur_close_q;
			o_low_q    <= cur_close_q;
			o_close_q  <= cur_close_q;
			o_vol_q    <= '0;
			o_gap_q    <= 1'b1;
			o_last_q   <= (fill_left_q == FILL_W'(1));
			gap_time_q <= gap_time_q + TW'(tf_eff);
		end
	end

	assign out_valid     = out_valid_q;
	assign bar_time      = o_time_q;
	assign bar_open      = o_open_q;
	assign bar_high      = o_high_q;
	assign bar_low       = o_low_q;
	assign bar_close     = o_close_q;
	assign bar_volume    = o_vol_q;
	assign gap_filled    = o_gap_q;
	assign gap_truncated = o_trunc_q;
	assign missing_total = o_missing_q;
	assign last_of_run   = o_last_q;

endmodule

>>> rtl/ohlcv_chk.sv
// Port-level checker for the bar resampler and its bind to the top level.
module ohlcv_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [ohlcv_pkg::TIME_W-1:0]  bar_time,
	input logic [ohlcv_pkg::PRICE_W-1:0] bar_open,
	input logic [ohlcv_pkg::PRICE_W-1:0] bar_high,
	input logic [ohlcv_pkg::PRICE_W-1:0] bar_low,
	input logic [ohlcv_pkg::PRICE_W-1:0] bar_close,
	input logic [ohlcv_pkg::VOL_W-1:0]   bar_volume,
	input logic                          gap_filled,
	input logic [ohlcv_pkg::CNT_W-1:0]   missing_total,
	input logic                          last_of_run
);

	// a held result keeps its time
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(bar_time))
		else $error("result changed while stalled");

	// no candle is taken while results of the previous one are pending
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("input ready during result delivery");

	// gap bars are flat at the last close with no volume
	a_gap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && gap_filled |-> bar_volume == '0 && bar_open == bar_close &&
		bar_high == bar_close && bar_low == bar_close)
		else $error("gap bar not flat");

	// a run continues with gap bars sharing the same missing count
	a_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_of_run |=> out_valid && gap_filled &&
		missing_total == $past(missing_total))
		else $error("result run broken");

endmodule

bind ohlcv_bar_resampler ohlcv_chk u_ohlcv_chk (.*);
